### design/cec_blr_pkg.sv
// Shared types and timing constants for the CEC bit-level receiver.
`timescale 1ns / 1ps

package cec_blr_pkg;

    // Field widths
    localparam int TIME_W     = 16;
    localparam int SUM_W      = TIME_W + 1;
    localparam int BYTE_W     = 8;
    localparam int BITPOS_W   = 4;
    localparam int BYTE_IDX_W = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 5;

    // Frame limits
    localparam int MAX_FRAME_BYTES = 16;

    // Timing windows in microseconds
    localparam int T_MARGIN          = 100;
    localparam int T_START_LOW_MIN   = 3500;
    localparam int T_START_LOW_MAX   = 3900;
    localparam int T_START_TOTAL_MAX = 5000 + T_MARGIN;
    localparam int T_DATA_TOTAL_MAX  = 2900 + T_MARGIN;
    localparam int T_BIT1_LOW_MAX    = 800;
    localparam int T_BIT0_LOW_MAX    = 1700;
    localparam int T_DATA_LOW_MAX    = 2750;
    localparam int T_LOW_DRIVE_LIMIT = 2400 * 14 / 10 - T_MARGIN;
    localparam int T_START_REJ_HIGH  = T_START_LOW_MAX + T_MARGIN * 5;
    localparam int T_START_REJ_LOW   = T_START_LOW_MIN - T_MARGIN * 6;
    localparam int T_DATA_REJ_LOW    = (T_BIT0_LOW_MAX > T_DATA_LOW_MAX) ?
                                       T_BIT0_LOW_MAX : T_DATA_LOW_MAX;
    localparam int T_BIT1_THRESHOLD  = T_BIT1_LOW_MAX + T_MARGIN;

    // Bit positions within a byte slot
    localparam logic [BITPOS_W-1:0] POS_LAST_DATA = BITPOS_W'(7);
    localparam logic [BITPOS_W-1:0] POS_EOM       = BITPOS_W'(8);
    localparam logic [BITPOS_W-1:0] POS_WRAP      = BITPOS_W'(10);

    localparam logic [BYTE_W-1:0] CDC_OPCODE = 8'hF8;

    // Receive phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_START = 3'b010,
        PH_DATA  = 3'b100
    } rx_phase_t;

    // One pin event
    typedef struct packed {
        logic              level_high;
        logic [TIME_W-1:0] elapsed_us;
    } pin_event_t;

    // One received byte with flags
    typedef struct packed {
        logic [BYTE_W-1:0]     data_byte;
        logic                  end_of_message;
        logic                  acked;
        logic                  broadcast;
        logic                  spurious;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic                  cdc_frame;
        logic                  message_complete;
    } rx_byte_t;

endpackage

### design/cec_blr_in_stage.sv
// Input register holding one pin event until the decoder consumes it.
`timescale 1ns / 1ps

module cec_blr_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tdata_level,
    input  logic [15:0]            s_tdata_time,
    input  logic                   advance,
    output logic                   held_valid,
    output cec_blr_pkg::pin_event_t held_event
);
    import cec_blr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    pin_event_t event_reg;

    // Take a new request when empty or when the held one moves on
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tvalid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            event_reg.level_high <= s_tdata_level;
            event_reg.elapsed_us <= s_tdata_time;
        end
    end

    assign held_valid = valid_reg;
    assign held_event = event_reg;

endmodule

### design/cec_blr_decoder.sv
// Receive state and per-event bit timing decode.
`timescale 1ns / 1ps

module cec_blr_decoder (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  cec_blr_pkg::pin_event_t evt,
    output logic                    res_hit,
    output cec_blr_pkg::rx_byte_t   res
);
    import cec_blr_pkg::*;

    rx_phase_t             phase_reg,      phase_next;
    logic                  prev_level_reg, prev_level_next;
    logic [TIME_W-1:0]     low_time_reg,   low_time_next;
    logic [BITPOS_W-1:0]   bit_pos_reg,    bit_pos_next;
    logic [BYTE_W-1:0]     shift_reg,      shift_next;
    logic                  eom_bit_reg,    eom_bit_next;
    logic                  eom_seen_reg,   eom_seen_next;
    logic [BYTE_IDX_W-1:0] frame_bytes_reg, frame_bytes_next;
    logic                  bcast_reg,      bcast_next;
    logic                  cdc_reg,        cdc_next;

    logic [SUM_W-1:0]  total_time;
    logic [TIME_W-1:0] us_min;
    logic              bit_val;
    logic              too_long;

    assign total_time = {1'b0, low_time_reg} + {1'b0, evt.elapsed_us};
    assign us_min     = (evt.elapsed_us > TIME_W'(T_MARGIN)) ?
                        evt.elapsed_us - TIME_W'(T_MARGIN) : '0;
    assign bit_val    = (low_time_reg < TIME_W'(T_BIT1_THRESHOLD));
    assign too_long   = (total_time > SUM_W'(T_DATA_TOTAL_MAX));

    // Work out the next state and any finished byte
    always_comb
    begin
        phase_next       = phase_reg;
        prev_level_next  = evt.level_high;
        low_time_next    = low_time_reg;
        bit_pos_next     = bit_pos_reg;
        shift_next       = shift_reg;
        eom_bit_next     = eom_bit_reg;
        eom_seen_next    = eom_seen_reg;
        frame_bytes_next = frame_bytes_reg;
        bcast_next       = bcast_reg;
        cdc_next         = cdc_reg;
        res_hit          = 1'b0;
        res              = '0;

        case (phase_reg)
            PH_START:
            begin
                eom_seen_next = 1'b0;
                if (prev_level_reg)
                begin
                    // End of start bit: accept or drop
                    if (evt.level_high || total_time > SUM_W'(T_START_TOTAL_MAX))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next       = PH_DATA;
                        bit_pos_next     = '0;
                        shift_next       = '0;
                        eom_bit_next     = 1'b0;
                        frame_bytes_next = '0;
                        bcast_next       = 1'b0;
                        cdc_next         = 1'b0;
                    end
                end
                else if (us_min > TIME_W'(T_START_REJ_HIGH))
                begin
                    phase_next = PH_IDLE;
                end
                else if (us_min < TIME_W'(T_START_REJ_LOW))
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    low_time_next = evt.elapsed_us;
                end
            end

            PH_DATA:
            begin
                if (prev_level_reg)
                begin
                    // Falling edge ends a data bit
                    if (bit_pos_reg <= POS_LAST_DATA)
                    begin
                        shift_next[~bit_pos_reg[2:0]] = shift_reg[~bit_pos_reg[2:0]] | bit_val;
                    end
                    else if (bit_pos_reg == POS_EOM)
                    begin
                        eom_bit_next = bit_val;
                    end
                    else
                    begin
                        // Acknowledge slot: emit the byte
                        if (frame_bytes_reg == '0)
                        begin
                            bcast_next = &shift_reg[3:0];
                        end
                        if (frame_bytes_reg == BYTE_IDX_W'(1) && shift_reg == CDC_OPCODE)
                        begin
                            cdc_next = 1'b1;
                        end
                        res_hit              = 1'b1;
                        res.data_byte        = shift_reg;
                        res.end_of_message   = eom_bit_reg;
                        res.acked            = (bcast_next == bit_val);
                        res.broadcast        = bcast_next;
                        res.spurious         = eom_seen_reg;
                        res.byte_index       = frame_bytes_reg;
                        res.cdc_frame        = cdc_next;
                        res.message_complete = eom_bit_reg &&
                                               (frame_bytes_reg >= BYTE_IDX_W'(2));
                        if (frame_bytes_reg < BYTE_IDX_W'(MAX_FRAME_BYTES))
                        begin
                            frame_bytes_next = frame_bytes_reg + BYTE_IDX_W'(1);
                        end
                        if (frame_bytes_next >= BYTE_IDX_W'(MAX_FRAME_BYTES))
                        begin
                            eom_seen_next = 1'b1;
                        end
                    end
                    bit_pos_next = bit_pos_reg + BITPOS_W'(1);

                    if ((evt.level_high || too_long) && !eom_bit_next)
                    begin
                        eom_seen_next = 1'b0;
                        phase_next    = evt.level_high ? PH_IDLE : PH_START;
                    end
                    else if (bit_pos_next >= POS_WRAP)
                    begin
                        if (eom_bit_next)
                        begin
                            eom_seen_next = 1'b1;
                            if (evt.level_high)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        bit_pos_next = '0;
                        shift_next   = '0;
                        eom_bit_next = 1'b0;
                    end
                end
                else
                begin
                    // Rising edge ends the low period: check for overlong drive
                    low_time_next = evt.elapsed_us;
                    if (evt.elapsed_us >= TIME_W'(T_LOW_DRIVE_LIMIT))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (us_min > TIME_W'(T_DATA_REJ_LOW))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end

            default:
            begin
                eom_seen_next = 1'b0;
                if (!evt.level_high)
                begin
                    phase_next = PH_START;
                end
            end
        endcase
    end

    // Advance state on each consumed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            prev_level_reg  <= 1'b1;
            low_time_reg    <= '0;
            bit_pos_reg     <= '0;
            shift_reg       <= '0;
            eom_bit_reg     <= 1'b0;
            eom_seen_reg    <= 1'b0;
            frame_bytes_reg <= '0;
            bcast_reg       <= 1'b0;
            cdc_reg         <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            prev_level_reg  <= prev_level_next;
            low_time_reg    <= low_time_next;
            bit_pos_reg     <= bit_pos_next;
            shift_reg       <= shift_next;
            eom_bit_reg     <= eom_bit_next;
            eom_seen_reg    <= eom_seen_next;
            frame_bytes_reg <= frame_bytes_next;
            bcast_reg       <= bcast_next;
            cdc_reg         <= cdc_next;
        end
    end

endmodule

### design/cec_blr_out_stage.sv
// Output register presenting one received byte to the downstream side.
`timescale 1ns / 1ps

module cec_blr_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  cec_blr_pkg::rx_byte_t res,
    output logic                  slot_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic [4:0]            m_tuser,
    output logic                  m_tlast
);
    import cec_blr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rx_byte_t byte_reg;

    // Free when empty or being drained this cycle
    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the byte until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, byte_reg.byte_index, byte_reg.data_byte};
    assign m_tuser  = {byte_reg.message_complete, byte_reg.cdc_frame, byte_reg.spurious,
                       byte_reg.broadcast, byte_reg.acked};
    assign m_tlast  = byte_reg.end_of_message;

endmodule

### design/cec_bit_level_receiver_top.sv
// Top level of the CEC bit-level receiver.
`timescale 1ns / 1ps

// Takes one CEC pin event per request (new line level on s_tuser, microseconds
// since the previous event on s_tdata) and decodes start bit, data bits, EOM and
// ACK against the standard timing windows, including the 3260 us low-drive abort.
// After each ACK bit one byte request leaves on the master side with its flags;
// other events produce nothing. An event passes through an input register, is
// decoded combinationally against the receive state and lands in the output
// register, so one event is taken every clock cycle unless the input stalls, and
// a byte is offered on the master side from the output register once the event
// that ends its ACK bit has been decoded. Only a full output register that is
// not being drained stalls the input, and only for an event that completes a byte.
// Frame byte positions saturate at 16.

module cec_bit_level_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] elapsed_us
    input  logic        s_tuser,   // [0] level_high
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [12:8] byte_index, [15:13] zero
    output logic [4:0]  m_tuser,   // [0] acked, [1] broadcast, [2] spurious,
                                   // [3] cdc_frame, [4] message_complete
    output logic        m_tlast    // end_of_message
);
    import cec_blr_pkg::*;

    logic       held_valid;
    pin_event_t held_event;
    logic       res_hit;
    rx_byte_t   res;
    logic       slot_free;
    logic       advance;

    // Move the held event on unless it yields a byte with nowhere to go
    assign advance = held_valid && (!res_hit || slot_free);

    cec_blr_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata_level (s_tuser),
        .s_tdata_time  (s_tdata),
        .advance       (advance),
        .held_valid    (held_valid),
        .held_event    (held_event)
    );

    cec_blr_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .evt     (held_event),
        .res_hit (res_hit),
        .res     (res)
    );

    cec_blr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_hit),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
